@@ hw/rtl/esaa_pkg.sv @@
// Shared types and constants of the ensemble score argmax accuracy unit.
package esaa_pkg;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned MAX_CLASSES = 16;

  localparam int unsigned SAMPLE_W = $clog2(MAX_SAMPLES);
  localparam int unsigned CLASS_W  = $clog2(MAX_CLASSES);
  localparam int unsigned ADDR_W   = SAMPLE_W + CLASS_W;
  localparam int unsigned NS_W     = SAMPLE_W + 1;
  localparam int unsigned NC_W     = CLASS_W + 1;
  localparam int unsigned SCORE_W  = 64;
  localparam int unsigned LABEL_W  = 8;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned MEMBER_W = 16;
  localparam int unsigned CFG_W    = 13;

  localparam logic [NS_W-1:0] NS_RESET = NS_W'(MAX_SAMPLES);
  localparam logic [NC_W-1:0] NC_RESET = NC_W'(10);
  localparam logic [NS_W-1:0] NS_MAX   = NS_W'(MAX_SAMPLES);
  localparam logic [NC_W-1:0] NC_MAX   = NC_W'(MAX_CLASSES);

  typedef enum logic [0:0] {
    CFG_NUM_SAMPLES = 1'b0,
    CFG_NUM_CLASSES = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_LABEL = 1'b0,
    OP_SCORE = 1'b1
  } op_e;

  typedef struct packed {
    logic                      en;
    logic [ADDR_W-1:0]         addr;
    logic [SCORE_W-1:0]        score;
  } sum_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      valid;
    logic [SCORE_W-1:0]        sum;
  } sum_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        correct_count;
    logic [MEMBER_W-1:0]       member_number;
    logic                      labels_present;
  } result_t;

endpackage

@@ hw/rtl/esaa_sum_store.sv @@
// Score sum memory with read-modify-write, write forwarding and clearing pass.
module esaa_sum_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  esaa_pkg::sum_req_t req_i,
  output esaa_pkg::sum_rsp_t rsp_o
);
  import esaa_pkg::*;

  localparam int unsigned DEPTH = MAX_SAMPLES * MAX_CLASSES;

  logic [SCORE_W-1:0] mem [DEPTH];

  logic [SCORE_W-1:0] rd_q;
  logic               s1_v_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [SCORE_W-1:0] s1_score_q;
  logic               fwd_q;
  logic [SCORE_W-1:0] fwd_data_q;
  logic               clr_q;
  logic [ADDR_W-1:0]  clr_addr_q;

  logic [SCORE_W-1:0] old_sum;
  logic [SCORE_W-1:0] new_sum;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SCORE_W-1:0] wr_data;

  assign old_sum = fwd_q ? fwd_data_q : rd_q;
  assign new_sum = old_sum + s1_score_q;

  assign wr_en   = clr_q | s1_v_q;
  assign wr_addr = clr_q ? clr_addr_q : s1_addr_q;
  assign wr_data = clr_q ? '0 : new_sum;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.en) begin
      rd_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      s1_addr_q  <= req_i.addr;
      s1_score_q <= req_i.score;
      fwd_q      <= s1_v_q && (s1_addr_q == req_i.addr);
      fwd_data_q <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      s1_v_q <= req_i.en;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy  = clr_q;
  assign rsp_o.valid = s1_v_q;
  assign rsp_o.sum   = new_sum;

endmodule

@@ hw/rtl/ensemble_score_argmax_accuracy_unit.sv @@
// Top level of the ensemble score argmax accuracy unit.
// A block's closing request passes the sum store stage; its result is then queued.
// Throughput: one request per cycle, but none while clearing or while the queue is
// full; one sum read-modify-write per in-range score request. Reset: a clearing pass
// zeroes all 65536 score sums, one entry per cycle. Configuration writes are taken
// throughout. A two-entry result queue decouples the output.
module ensemble_score_argmax_accuracy_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_index_i,
  input  logic [esaa_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [esaa_pkg::SAMPLE_W-1:0]     sample_index_i,
  input  logic [esaa_pkg::CLASS_W-1:0]      class_index_i,
  input  logic [esaa_pkg::LABEL_W-1:0]      label_value_i,
  input  logic signed [esaa_pkg::SCORE_W-1:0] score_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [esaa_pkg::COUNT_W-1:0]      correct_count_o,
  output logic [esaa_pkg::MEMBER_W-1:0]     member_number_o,
  output logic                              labels_present_o
);
  import esaa_pkg::*;

  logic [LABEL_W-1:0] lmem [MAX_SAMPLES];

  logic [NS_W-1:0]     ns_q;
  logic [NC_W-1:0]     nc_q;
  logic [NS_W-1:0]     ns_eff;
  logic [NC_W-1:0]     nc_eff;

  logic                in_fire;
  logic                lbl_wr;
  logic                in_range;
  logic                sc_acc;
  sum_req_t            sreq;
  sum_rsp_t            srsp;

  logic [LABEL_W-1:0]  lab_rd_q;
  logic [CLASS_W-1:0]  s1_cls_q;
  logic                s1_last_cls_q;
  logic                s1_last_smp_q;

  logic [SCORE_W-1:0]  best_val_q;
  logic [CLASS_W-1:0]  best_cls_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [MEMBER_W-1:0] member_q;
  logic                lbl_seen_q;

  logic                take;
  logic [CLASS_W-1:0]  best_cls_new;
  logic                match;
  logic [COUNT_W-1:0]  cnt_new;
  logic                emit;
  result_t             res;

  result_t             fifo_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic [1:0]          fcnt_q;
  logic                deq;
  logic [2:0]          occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q <= NS_RESET;
      nc_q <= NC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_SAMPLES: ns_q <= cfg_data_i[NS_W-1:0];
        CFG_NUM_CLASSES: nc_q <= cfg_data_i[NC_W-1:0];
        default: ;
      endcase
    end
  end

  assign ns_eff = (ns_q == '0) ? NS_W'(1) : ((ns_q > NS_MAX) ? NS_MAX : ns_q);
  assign nc_eff = (nc_q < NC_W'(2)) ? NC_W'(2) : ((nc_q > NC_MAX) ? NC_MAX : nc_q);

  assign deq  = out_valid_o && out_ready_i;
  assign emit = srsp.valid && s1_last_cls_q && s1_last_smp_q;
  assign occ  = {1'b0, fcnt_q} + {2'b00, emit};

  assign in_ready_o = !srsp.busy && ((occ <= 3'd1) || ((occ == 3'd2) && deq));
  assign in_fire    = in_valid_i && in_ready_o;
  assign lbl_wr     = in_fire && (op_e'(operation_i) == OP_LABEL);
  assign in_range   = ({1'b0, sample_index_i} < ns_eff) && ({1'b0, class_index_i} < nc_eff);
  assign sc_acc     = in_fire && (op_e'(operation_i) == OP_SCORE) && in_range;

  assign sreq.en    = sc_acc;
  assign sreq.addr  = {sample_index_i, class_index_i};
  assign sreq.score = score_value_i;

  esaa_sum_store u_sum_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rsp_o  (srsp)
  );

  always_ff @(posedge clk_i) begin
    if (lbl_wr) begin
      lmem[sample_index_i] <= label_value_i;
    end
    if (sc_acc) begin
      lab_rd_q <= lmem[sample_index_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_acc) begin
      s1_cls_q      <= class_index_i;
      s1_last_cls_q <= ({1'b0, class_index_i} == (nc_eff - NC_W'(1)));
      s1_last_smp_q <= ({1'b0, sample_index_i} == (ns_eff - NS_W'(1)));
    end
  end

  always_comb begin
    take         = (s1_cls_q == '0) || ($signed(srsp.sum) > $signed(best_val_q));
    best_cls_new = take ? s1_cls_q : best_cls_q;
    match        = lbl_seen_q && (lab_rd_q == {{(LABEL_W-CLASS_W){1'b0}}, best_cls_new});
    cnt_new      = cnt_q + {{(COUNT_W-1){1'b0}}, match};
    res.correct_count  = lbl_seen_q ? cnt_new : '0;
    res.member_number  = member_q + 1'b1;
    res.labels_present = lbl_seen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_val_q <= '0;
      best_cls_q <= '0;
      cnt_q      <= '0;
      member_q   <= '0;
      lbl_seen_q <= 1'b0;
    end else begin
      if (lbl_wr) begin
        lbl_seen_q <= 1'b1;
      end
      if (srsp.valid) begin
        if (take) begin
          best_val_q <= srsp.sum;
          best_cls_q <= s1_cls_q;
        end
        if (s1_last_cls_q) begin
          cnt_q <= s1_last_smp_q ? '0 : cnt_new;
        end
        if (emit) begin
          member_q <= res.member_number;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fcnt_q   <= '0;
    end else begin
      if (emit) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fcnt_q <= fcnt_q + {1'b0, emit} - {1'b0, deq};
    end
  end

  assign out_valid_o      = (fcnt_q != '0);
  assign correct_count_o  = fifo_q[rd_ptr_q].correct_count;
  assign member_number_o  = fifo_q[rd_ptr_q].member_number;
  assign labels_present_o = fifo_q[rd_ptr_q].labels_present;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the ensemble score argmax accuracy unit, directed rows then random votes.
module testbench;
  import esaa_pkg::*;

  localparam int unsigned ITEMS         = 1950;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned NUM_ROWS      = 23;

  localparam logic [SCORE_W-1:0] SCORE_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_BOTTOM = 64'h8000_0000_0000_0000;
  localparam logic [SCORE_W-1:0] SCORE_ONES   = '1;
  localparam result_t            NO_TALLY     = '0;

  typedef enum bit {
    STIM_REQ,
    STIM_REGS
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e           kind;
    logic [CFG_W-1:0]     ns_raw;
    logic [CFG_W-1:0]     nc_raw;
    op_e                  op;
    logic [SAMPLE_W-1:0]  smp;
    logic [CLASS_W-1:0]   cls;
    logic [LABEL_W-1:0]   label;
    logic [SCORE_W-1:0]   score;
    bit                   typed;
    result_t              want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [0:0]          cfg_index_i = CFG_NUM_SAMPLES;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                operation_i = OP_LABEL;
  logic [SAMPLE_W-1:0] sample_index_i = '0;
  logic [CLASS_W-1:0]  class_index_i = '0;
  logic [LABEL_W-1:0]  label_value_i = '0;
  logic signed [SCORE_W-1:0] score_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [COUNT_W-1:0]  correct_count_o;
  logic [MEMBER_W-1:0] member_number_o;
  logic                labels_present_o;

  ensemble_score_argmax_accuracy_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .sample_index_i   (sample_index_i),
    .class_index_i    (class_index_i),
    .label_value_i    (label_value_i),
    .score_value_i    (score_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .correct_count_o  (correct_count_o),
    .member_number_o  (member_number_o),
    .labels_present_o (labels_present_o)
  );

  // vote predictor state
  bit [SCORE_W-1:0]  vote_sum [MAX_SAMPLES*MAX_CLASSES];
  bit [LABEL_W-1:0]  label_mem [MAX_SAMPLES];
  bit                label_known [MAX_SAMPLES];
  bit [SCORE_W-1:0]  best_sum;
  bit [CLASS_W-1:0]  best_cls;
  bit [COUNT_W-1:0]  hit_count;
  bit [MEMBER_W-1:0] member_count;
  bit                labels_seen;
  bit [CFG_W-1:0]    ns_reg = CFG_W'(MAX_SAMPLES);
  bit [4:0]          nc_reg = 5'd10;

  result_t     due_tallies [$];
  stim_row_t   dir_rows [NUM_ROWS];
  int unsigned request_count;
  int unsigned tally_count;
  int unsigned mismatch_count;
  int unsigned setting_count;
  int unsigned cycle_count;
  bit          quiet;
  bit          sender_gappy = 1'b1;
  int unsigned stall_left;
  int unsigned run_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int unsigned eff_samples();
    if (ns_reg == 0) return 1;
    if (ns_reg > MAX_SAMPLES) return MAX_SAMPLES;
    return ns_reg;
  endfunction

  function automatic int unsigned eff_classes();
    if (nc_reg < 2) return 2;
    if (nc_reg > MAX_CLASSES) return MAX_CLASSES;
    return nc_reg;
  endfunction

  function automatic bit predict_vote(input op_e op, input logic [SAMPLE_W-1:0] smp,
                                      input logic [CLASS_W-1:0] cls,
                                      input logic [LABEL_W-1:0] lab,
                                      input logic [SCORE_W-1:0] sc, output result_t tally);
    int unsigned       ns;
    int unsigned       nc;
    int unsigned       slot;
    bit [SCORE_W-1:0]  acc;
    tally = '0;
    ns = eff_samples();
    nc = eff_classes();
    if (op == OP_LABEL) begin
      label_mem[smp] = lab;
      label_known[smp] = 1'b1;
      labels_seen = 1'b1;
      return 1'b0;
    end
    if (smp >= ns || cls >= nc) return 1'b0;
    slot = smp * MAX_CLASSES + cls;
    acc = vote_sum[slot] + sc;
    vote_sum[slot] = acc;
    if (cls == 0 || $signed(acc) > $signed(best_sum)) begin
      best_sum = acc;
      best_cls = cls;
    end
    if (cls != nc - 1) return 1'b0;
    if (labels_seen && label_mem[smp] == LABEL_W'(best_cls)) hit_count = hit_count + 1'b1;
    if (smp != ns - 1) return 1'b0;
    member_count = member_count + 1'b1;
    tally.correct_count = labels_seen ? hit_count : '0;
    tally.member_number = member_count;
    tally.labels_present = labels_seen;
    hit_count = '0;
    return 1'b1;
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    logic [SCORE_W-1:0] sc;
    case ($urandom_range(0, 9))
      0: sc = SCORE_TOP;
      1: sc = SCORE_BOTTOM;
      2: sc = SCORE_W'($urandom_range(0, 8)) - SCORE_W'(4);
      3: sc = '0;
      default: sc = {$urandom, $urandom};
    endcase
    return sc;
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label(input int unsigned nc);
    if ($urandom_range(0, 7) == 0) return LABEL_W'($urandom);
    return LABEL_W'($urandom_range(0, nc - 1));
  endfunction

  task automatic report_miss(input string what, input longint unsigned got,
                             input longint unsigned want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_tallies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [CFG_W-1:0] ns_raw, input logic [CFG_W-1:0] nc_raw);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_NUM_SAMPLES;
    cfg_data_i <= ns_raw;
    @(posedge clk_i);
    cfg_index_i <= CFG_NUM_CLASSES;
    cfg_data_i <= nc_raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ns_reg = ns_raw;
    nc_reg = nc_raw[4:0];
    setting_count++;
  endtask

  task automatic push_request(input op_e op, input logic [SAMPLE_W-1:0] smp,
                              input logic [CLASS_W-1:0] cls, input logic [LABEL_W-1:0] lab,
                              input logic [SCORE_W-1:0] sc, input bit typed,
                              input result_t want);
    result_t tally;
    bit      closes;
    bit      counted;
    in_valid_i <= 1'b1;
    operation_i <= op;
    sample_index_i <= smp;
    class_index_i <= cls;
    label_value_i <= lab;
    score_value_i <= sc;
    counted = (op == OP_LABEL) || (smp < eff_samples() && cls < eff_classes());
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    closes = predict_vote(op, smp, cls, lab, sc, tally);
    if (closes) due_tallies.push_back(typed ? want : tally);
    if (counted) request_count++;
    if (request_count >= ITEMS * 85 / 100) quiet = 1'b1;
    if (!quiet && sender_gappy && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // once any label exists, write the label first when a row would close on a sample never labeled
  task automatic issue(input op_e op, input logic [SAMPLE_W-1:0] smp,
                       input logic [CLASS_W-1:0] cls, input logic [LABEL_W-1:0] lab,
                       input logic [SCORE_W-1:0] sc, input bit typed, input result_t want);
    if (op == OP_SCORE && labels_seen && !label_known[smp] && smp < eff_samples() &&
        cls == eff_classes() - 1)
      push_request(OP_LABEL, smp, cls, pick_label(eff_classes()), sc, 1'b0, NO_TALLY);
    push_request(op, smp, cls, lab, sc, typed, want);
  endtask

  always @(posedge clk_i) begin
    if (quiet || run_left > 0) begin
      if (run_left > 0) run_left--;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready_i <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 40);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : tally_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_tallies.size() == 0) begin
        report_miss("unexpected result, correct_count", correct_count_o, 0);
      end else begin
        want = due_tallies.pop_front();
        tally_count++;
        if (correct_count_o !== want.correct_count)
          report_miss("correct_count", correct_count_o, want.correct_count);
        if (member_number_o !== want.member_number)
          report_miss("member_number", member_number_o, want.member_number);
        if (labels_present_o !== want.labels_present)
          report_miss("labels_present", labels_present_o, want.labels_present);
      end
    end
  end

  initial begin
    int unsigned       ns;
    int unsigned       nc;
    int unsigned       noise;
    logic [CFG_W-1:0]  ns_raw;
    logic [CFG_W-1:0]  nc_raw;

    dir_rows = '{
      '{STIM_REGS, 13'd1, 13'd2, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd5, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd1, 8'd0, 64'd3, 1'b1,
        '{13'd0, 16'd1, 1'b0}},
      '{STIM_REQ, 13'd0, 13'd0, OP_LABEL, 12'd0, 4'd15, 8'd0, SCORE_ONES, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_LABEL, 12'd4095, 4'd0, 8'd255, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd0, 8'd0, SCORE_TOP, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd1, 8'd0, SCORE_BOTTOM, 1'b1,
        '{13'd1, 16'd2, 1'b1}},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd4095, 4'd0, 8'd0, 64'd9, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd15, 8'd0, 64'd9, 1'b0, NO_TALLY},
      '{STIM_REGS, 13'd8191, 13'd31, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd4095, 4'd15, 8'd0, SCORE_ONES, 1'b1,
        '{13'd0, 16'd3, 1'b1}},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd4095, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_LABEL, 12'd4095, 4'd7, 8'd15, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd4095, 4'd15, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REGS, 13'd0, 13'd1, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd1, 8'd0, 64'd1, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_LABEL, 12'd0, 4'd0, 8'd1, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd0, 4'd1, 8'd0, 64'd2, 1'b0, NO_TALLY},
      '{STIM_REGS, 13'd2, 13'd16, OP_SCORE, 12'd0, 4'd0, 8'd0, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_LABEL, 12'd1, 4'd0, 8'd16, 64'd0, 1'b0, NO_TALLY},
      '{STIM_REQ, 13'd0, 13'd0, OP_SCORE, 12'd1, 4'd15, 8'd0, SCORE_TOP, 1'b0, NO_TALLY}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == STIM_REGS)
        set_counts(dir_rows[i].ns_raw, dir_rows[i].nc_raw);
      else
        issue(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].cls, dir_rows[i].label,
              dir_rows[i].score, dir_rows[i].typed, dir_rows[i].want);
    end

    while (request_count < ITEMS) begin
      case ($urandom_range(0, 9))
        0: ns_raw = '0;
        1: ns_raw = CFG_W'($urandom);
        2: ns_raw = $urandom_range(0, 1) ? CFG_W'(MAX_SAMPLES) : '1;
        default: ns_raw = CFG_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0: nc_raw = CFG_W'($urandom);
        1: nc_raw = CFG_W'($urandom_range(0, 1));
        2: nc_raw = CFG_W'(MAX_CLASSES);
        3: nc_raw = CFG_W'(31);
        default: nc_raw = CFG_W'($urandom_range(2, 16));
      endcase
      set_counts(ns_raw, nc_raw);
      sender_gappy = $urandom_range(0, 2) != 0;
      ns = eff_samples();
      nc = eff_classes();
      if (ns > 8) begin
        // sparse votes over a wide sample range, then close the block
        repeat (2) begin
          repeat ($urandom_range(4, 16))
            issue(OP_SCORE, SAMPLE_W'($urandom_range(0, ns - 1)),
                  CLASS_W'($urandom_range(0, nc - 1)), LABEL_W'($urandom), pick_score(),
                  1'b0, NO_TALLY);
          issue(OP_SCORE, SAMPLE_W'(ns - 1), CLASS_W'(nc - 1), LABEL_W'($urandom),
                pick_score(), 1'b0, NO_TALLY);
        end
      end else begin
        for (int unsigned s = 0; s < ns; s++)
          if (!label_known[s] || $urandom_range(0, 1))
            issue(OP_LABEL, SAMPLE_W'(s), CLASS_W'($urandom), pick_label(nc), pick_score(),
                  1'b0, NO_TALLY);
        repeat ($urandom_range(1, 3)) begin
          for (int unsigned s = 0; s < ns; s++) begin
            for (int unsigned c = 0; c < nc; c++) begin
              noise = $urandom_range(0, 39);
              if (noise == 0)
                issue(OP_LABEL, SAMPLE_W'($urandom), CLASS_W'($urandom), pick_label(nc),
                      pick_score(), 1'b0, NO_TALLY);
              if (noise == 1) begin
                if (nc < MAX_CLASSES && $urandom_range(0, 1))
                  issue(OP_SCORE, SAMPLE_W'(s), CLASS_W'($urandom_range(nc, MAX_CLASSES - 1)),
                        LABEL_W'($urandom), pick_score(), 1'b0, NO_TALLY);
                else
                  issue(OP_SCORE, SAMPLE_W'($urandom_range(ns, MAX_SAMPLES - 1)),
                        CLASS_W'($urandom), LABEL_W'($urandom), pick_score(), 1'b0, NO_TALLY);
              end
              // drop one element now and then, repeat another
              if (noise != 2)
                issue(OP_SCORE, SAMPLE_W'(s), CLASS_W'(c), LABEL_W'($urandom), pick_score(),
                      1'b0, NO_TALLY);
              if (noise == 3)
                issue(OP_SCORE, SAMPLE_W'(s), CLASS_W'(c), LABEL_W'($urandom), pick_score(),
                      1'b0, NO_TALLY);
            end
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (due_tallies.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (due_tallies.size() != 0) report_miss("tallies left over", due_tallies.size(), 0);

    $display("covered %0d requests over %0d register settings, sample counts 1 to %0d",
             request_count, setting_count, MAX_SAMPLES);
    $display("checked %0d member tallies, class counts 2 to %0d, %0d mismatches",
             tally_count, MAX_CLASSES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
